@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on clk_i, disabled while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form of the above.
`define ASSERT_IMPL(label, pre, post, msg) \
  `ASSERT_CLK(label, (pre) |-> (post), msg)

`endif

@@ rtl/bfp_pkg.sv @@
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared types and constants of the MSB-first bit field packer.
// ----------------------------------------------------------------------------
package bfp_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned BitCntW = 7;
  localparam int unsigned ByteCntW = 3;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned FillW   = 3;
  localparam int unsigned RemW    = 7;
  localparam int unsigned WordW   = ValueW + ByteW;

  localparam logic [BitCntW-1:0]  MaxFieldBits = 7'd64;
  localparam logic [ByteCntW-1:0] MaxWordBytes = 3'd4;

  localparam logic [CmdW-1:0] CmdAppend = 2'd0;
  localparam logic [CmdW-1:0] CmdWrite  = 2'd1;
  localparam logic [CmdW-1:0] CmdAlign  = 2'd2;

  typedef struct packed {
    logic load;
    logic shift;
    logic commit;
  } ctrl_t;

  typedef struct packed {
    logic             rem_ge8;
    logic             last;
    logic [ByteW-1:0] top;
  } stat_t;

endpackage

@@ rtl/bfp_datapath.sv @@
// ----------------------------------------------------------------------------
// bfp_datapath
// Alignment loader and byte shifter holding the pending bit word and state.
// ----------------------------------------------------------------------------
module bfp_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bfp_pkg::ctrl_t                  ctrl_i,
  input  logic [bfp_pkg::CmdW-1:0]        command_i,
  input  logic [bfp_pkg::BitCntW-1:0]     bit_count_i,
  input  logic [bfp_pkg::ByteCntW-1:0]    byte_count_i,
  input  logic [bfp_pkg::ValueW-1:0]      value_i,
  output bfp_pkg::stat_t                  stat_o
);

  logic [bfp_pkg::WordW-1:0]  word_q, word_d;
  logic [bfp_pkg::RemW-1:0]   rem_q, rem_d;
  logic [bfp_pkg::ByteW-1:0]  partial_q, partial_d;
  logic [bfp_pkg::FillW-1:0]  fill_q, fill_d;

  logic [bfp_pkg::BitCntW-1:0]  cnt_sat;
  logic [bfp_pkg::ByteCntW-1:0] nb_sat;
  logic [bfp_pkg::ValueW-1:0]   val_just;
  logic [31:0]                  val_rev;
  logic                         has_part;
  logic [bfp_pkg::WordW-1:0]    load_word;
  logic [bfp_pkg::RemW-1:0]     load_rem;

  always_comb begin
    cnt_sat  = (bit_count_i > bfp_pkg::MaxFieldBits) ? bfp_pkg::MaxFieldBits : bit_count_i;
    nb_sat   = (byte_count_i > bfp_pkg::MaxWordBytes) ? bfp_pkg::MaxWordBytes : byte_count_i;
    val_just = value_i << (bfp_pkg::MaxFieldBits - cnt_sat);
    val_rev  = {value_i[7:0], value_i[15:8], value_i[23:16], value_i[31:24]};
    has_part = (fill_q != '0);
    unique case (command_i)
      bfp_pkg::CmdAppend: begin
        load_word = {partial_q, {bfp_pkg::ValueW{1'b0}}}
                  | ({val_just, {bfp_pkg::ByteW{1'b0}}} >> fill_q);
        load_rem  = {{(bfp_pkg::RemW-bfp_pkg::FillW){1'b0}}, fill_q} + cnt_sat;
      end
      bfp_pkg::CmdWrite: begin
        load_word = has_part ? {partial_q, val_rev, 32'd0} : {val_rev, 40'd0};
        load_rem  = (has_part ? 7'd8 : 7'd0) + {1'b0, nb_sat, 3'd0};
      end
      bfp_pkg::CmdAlign: begin
        load_word = {partial_q, {bfp_pkg::ValueW{1'b0}}};
        load_rem  = has_part ? 7'd8 : 7'd0;
      end
      default: begin
        load_word = {partial_q, {bfp_pkg::ValueW{1'b0}}};
        load_rem  = {{(bfp_pkg::RemW-bfp_pkg::FillW){1'b0}}, fill_q};
      end
    endcase
  end

  always_comb begin
    word_d    = word_q;
    rem_d     = rem_q;
    partial_d = partial_q;
    fill_d    = fill_q;
    if (ctrl_i.load) begin
      word_d = load_word;
      rem_d  = load_rem;
    end else if (ctrl_i.shift) begin
      word_d = {word_q[bfp_pkg::WordW-bfp_pkg::ByteW-1:0], {bfp_pkg::ByteW{1'b0}}};
      rem_d  = rem_q - 7'd8;
    end
    if (ctrl_i.commit) begin
      fill_d    = rem_q[bfp_pkg::FillW-1:0];
      partial_d = word_q[bfp_pkg::WordW-1 -: bfp_pkg::ByteW]
                & ~(8'hFF >> rem_q[bfp_pkg::FillW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      partial_q <= '0;
      fill_q    <= '0;
    end else begin
      rem_q     <= rem_d;
      partial_q <= partial_d;
      fill_q    <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign stat_o.rem_ge8 = |rem_q[bfp_pkg::RemW-1:3];
  assign stat_o.last    = ~|rem_q[bfp_pkg::RemW-1:4];
  assign stat_o.top     = word_q[bfp_pkg::WordW-1 -: bfp_pkg::ByteW];

endmodule

@@ rtl/msb_first_bit_field_packer_unit.sv @@
// ----------------------------------------------------------------------------
// msb_first_bit_field_packer_unit
// Packs bit fields MSB first into a byte stream; aligns and writes LE bytes.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                         Marker
//  s_axis    in   tuser: command; tdata: bit_count,byte_count,value  -
//  m_axis    out  tdata: out_byte                                 tlast: last_byte
//
//  An item is loaded, then emits its bytes (0 to 8) one per cycle through the
//  shared 72-bit byte shifter while the output is free, then stores the
//  leftover bits. Output stalls hold the shifter.
//  Reset clears the partial byte and fill count; no item is taken while busy.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msb_first_bit_field_packer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [79:0] s_axis_tdata_i,  // bit_count[6:0], byte_count[9:7], value[73:10]
  input  logic [1:0]  s_axis_tuser_i,  // command[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // out_byte[7:0]
  output logic        m_axis_tlast_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic           state_q, state_d;
  logic           ov_q, ov_d;
  logic [7:0]     ob_q, ob_d;
  logic           ol_q, ol_d;
  logic           accept, out_free;
  bfp_pkg::ctrl_t ctrl;
  bfp_pkg::stat_t stat;

  bfp_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .command_i    (s_axis_tuser_i),
    .bit_count_i  (s_axis_tdata_i[6:0]),
    .byte_count_i (s_axis_tdata_i[9:7]),
    .value_i      (s_axis_tdata_i[73:10]),
    .stat_o       (stat)
  );

  assign s_axis_tready_o = (state_q == StIdle);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~ov_q | m_axis_tready_i;

  always_comb begin
    state_d     = state_q;
    ov_d        = ov_q & ~m_axis_tready_i;
    ob_d        = ob_q;
    ol_d        = ol_q;
    ctrl.load   = 1'b0;
    ctrl.shift  = 1'b0;
    ctrl.commit = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          ctrl.load = 1'b1;
          state_d   = StRun;
        end
      end
      StRun: begin
        if (stat.rem_ge8) begin
          if (out_free) begin
            ov_d       = 1'b1;
            ob_d       = stat.top;
            ol_d       = stat.last;
            ctrl.shift = 1'b1;
          end
        end else begin
          ctrl.commit = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
    ol_q <= ol_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = ob_q;
  assign m_axis_tlast_o  = ol_q;

  `ASSERT_CLK(a_accept_starts_run, accept |=> (state_q == StRun), "accept did not start run")
  `ASSERT_IMPL(a_idle_no_bytes, state_q == StIdle, !stat.rem_ge8, "bytes pending while idle")
  `ASSERT_IMPL(a_commit_no_shift, ctrl.commit, !ctrl.shift && !ctrl.load, "commit clash")

endmodule

@@ bench/bfp_stream_checker.sv @@
// ----------------------------------------------------------------------------
// bfp_stream_checker
// Watches both stream channels of the bit field packer. Every accepted input
// item is run through a cycle-free model of the packer; the bytes it produces
// are queued and each accepted output byte is compared with the oldest one.
// ----------------------------------------------------------------------------
module bfp_stream_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  input  logic               s_axis_tready_i,
  input  logic [79:0]        s_axis_tdata_i,  // bit_count[6:0], byte_count[9:7], value[73:10]
  input  logic [1:0]         s_axis_tuser_i,  // command[1:0]
  input  logic               m_axis_tvalid_i,
  input  logic               m_axis_tready_i,
  input  logic [7:0]         m_axis_tdata_i,  // out_byte[7:0]
  input  logic               m_axis_tlast_i,
  output int unsigned        fail_cnt_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [bfp_pkg::ByteW-1:0] data;
    logic                      last;
  } packed_byte_t;

  packed_byte_t              packed_byte_q[$];
  logic [bfp_pkg::ByteW-1:0] acc_byte;
  logic [bfp_pkg::FillW-1:0] acc_fill;

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
    checked_o  = 0;
    acc_byte   = '0;
    acc_fill   = '0;
  end

  task automatic predict_packed_bytes(input logic [bfp_pkg::CmdW-1:0]     cmd,
                                      input logic [bfp_pkg::BitCntW-1:0]  nbits,
                                      input logic [bfp_pkg::ByteCntW-1:0] nbytes,
                                      input logic [bfp_pkg::ValueW-1:0]   val);
    logic [bfp_pkg::ByteW-1:0] bytes [8];
    int                        n;
    int                        cnt;
    n = 0;
    case (cmd) inside
      bfp_pkg::CmdAppend: begin
        cnt = (nbits > bfp_pkg::MaxFieldBits) ? int'(bfp_pkg::MaxFieldBits) : int'(nbits);
        for (int i = cnt - 1; i >= 0; i--) begin
          acc_byte[3'd7 - acc_fill] = val[i];
          acc_fill = acc_fill + 3'd1;
          if (acc_fill == '0) begin
            bytes[n] = acc_byte;
            n++;
            acc_byte = '0;
          end
        end
      end
      bfp_pkg::CmdWrite, bfp_pkg::CmdAlign: begin
        if (acc_fill != '0) begin
          bytes[n] = acc_byte;
          n++;
          acc_byte = '0;
          acc_fill = '0;
        end
        if (cmd == bfp_pkg::CmdWrite) begin
          cnt = (nbytes > bfp_pkg::MaxWordBytes) ? int'(bfp_pkg::MaxWordBytes)
                                                 : int'(nbytes);
          for (int k = 0; k < cnt; k++) begin
            bytes[n] = val[8*k +: 8];
            n++;
          end
        end
      end
      default: ;
    endcase
    for (int j = 0; j < n; j++) packed_byte_q.push_back({bytes[j], j == n - 1});
  endtask

  always @(posedge clk_i) begin
    packed_byte_t want;
    if (!rst_ni) begin
      acc_byte = '0;
      acc_fill = '0;
      packed_byte_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (packed_byte_q.size() == 0) begin
          if (fail_cnt_o < 10)
            $display("%0t: unexpected output byte %02h last %0b", $realtime,
                     m_axis_tdata_i, m_axis_tlast_i);
          fail_cnt_o++;
        end else begin
          want = packed_byte_q.pop_front();
          if (want.data !== m_axis_tdata_i || want.last !== m_axis_tlast_i) begin
            if (fail_cnt_o < 10)
              $display("%0t: byte %0d mismatch: expected %02h last %0b, got %02h last %0b",
                       $realtime, checked_o, want.data, want.last,
                       m_axis_tdata_i, m_axis_tlast_i);
            fail_cnt_o++;
          end
          checked_o++;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        predict_packed_bytes(s_axis_tuser_i, s_axis_tdata_i[6:0], s_axis_tdata_i[9:7],
                             s_axis_tdata_i[73:10]);
    end
    pending_o = packed_byte_q.size();
  end

endmodule

@@ bench/msb_first_bit_field_packer_unit_test.sv @@
// ----------------------------------------------------------------------------
// msb_first_bit_field_packer_unit_test
// Drives the packer with a directed run of edge cases, then random commands
// under several idle and stall mixes, including one long output hold-off that
// backs the block up. A separate checker predicts and compares every byte.
// ----------------------------------------------------------------------------
module msb_first_bit_field_packer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bfp_pkg::CmdW-1:0] CmdUnused = 2'd3;
  localparam int unsigned              LongHold  = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned checked;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  logic        long_hold_req = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned cmd_seen [4];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("msb_first_bit_field_packer_unit test failed");
    $finish;
  end

  msb_first_bit_field_packer_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  bfp_stream_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  // hold off for a long stretch on request, else stall at random
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (long_hold_req && hold_cnt < LongHold) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt + 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [bfp_pkg::CmdW-1:0]     cmd,
                           input logic [bfp_pkg::BitCntW-1:0]  nbits,
                           input logic [bfp_pkg::ByteCntW-1:0] nbytes,
                           input logic [bfp_pkg::ValueW-1:0]   val);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {6'b0, val, nbytes, nbits};
    cmd_seen[cmd]++;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_item();
    logic [bfp_pkg::CmdW-1:0]     cmd;
    logic [bfp_pkg::BitCntW-1:0]  nbits;
    logic [bfp_pkg::ByteCntW-1:0] nbytes;
    logic [bfp_pkg::ValueW-1:0]   val;
    int unsigned                  r;
    r = $urandom_range(0, 99);
    if (r < 55)      cmd = bfp_pkg::CmdAppend;
    else if (r < 80) cmd = bfp_pkg::CmdWrite;
    else if (r < 92) cmd = bfp_pkg::CmdAlign;
    else             cmd = CmdUnused;
    r = $urandom_range(0, 99);
    if (r < 10)      nbits = 7'($urandom_range(65, 127));
    else if (r < 20) nbits = bfp_pkg::MaxFieldBits;
    else if (r < 27) nbits = '0;
    else             nbits = 7'($urandom_range(1, 63));
    r = $urandom_range(0, 99);
    if (r < 85)      nbytes = 3'(1 << $urandom_range(0, 2));
    else             nbytes = 3'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 5)       val = '1;
    else if (r < 10) val = '0;
    else             val = {$urandom, $urandom};
    send_item(cmd, nbits, nbytes, val);
  endtask

  initial begin
    int unsigned phase_src [5];
    int unsigned phase_sink [5];
    int unsigned phase_items [5];
    int unsigned guard;
    phase_src   = '{0, 74, 0, 15, 0};
    phase_sink  = '{0, 0, 74, 15, 0};
    phase_items = '{70, 70, 70, 70, 50};
    for (int c = 0; c < 4; c++) cmd_seen[c] = 0;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(bfp_pkg::CmdAppend, 7'd0,   3'd0, '1);
    send_item(bfp_pkg::CmdAppend, 7'd1,   3'd0, 64'h1);
    send_item(bfp_pkg::CmdAppend, 7'd64,  3'd7, '1);
    send_item(bfp_pkg::CmdAppend, 7'd6,   3'd0, '0);
    send_item(bfp_pkg::CmdAppend, 7'd64,  3'd0, 64'hA5C3_0F96_5A3C_F069);
    send_item(CmdUnused,          7'd64,  3'd4, '1);
    send_item(bfp_pkg::CmdAlign,  7'd0,   3'd0, '1);
    send_item(bfp_pkg::CmdAlign,  7'd127, 3'd7, '1);
    send_item(bfp_pkg::CmdWrite,  7'd0,   3'd1, '1);
    send_item(bfp_pkg::CmdWrite,  7'd0,   3'd2, 64'h0000_0000_0000_BEEF);
    send_item(bfp_pkg::CmdWrite,  7'd0,   3'd4, 64'h0123_4567_89AB_CDEF);
    send_item(bfp_pkg::CmdAppend, 7'd3,   3'd0, 64'h5);
    send_item(bfp_pkg::CmdWrite,  7'd0,   3'd0, '1);
    send_item(bfp_pkg::CmdAppend, 7'd127, 3'd0, '1);
    send_item(bfp_pkg::CmdAppend, 7'd65,  3'd0, '0);
    send_item(bfp_pkg::CmdAppend, 7'd5,   3'd0, 64'h1B);
    send_item(bfp_pkg::CmdWrite,  7'd0,   3'd7, 64'hFEDC_BA98_7654_3210);
    send_item(bfp_pkg::CmdWrite,  7'd0,   3'd3, 64'h0000_0000_00C0_FFEE);
    send_item(bfp_pkg::CmdAppend, 7'd8,   3'd0, '0);
    send_item(bfp_pkg::CmdAppend, 7'd8,   3'd0, 64'hFF);
    send_item(bfp_pkg::CmdAppend, 7'd4,   3'd0, 64'h9);
    send_item(bfp_pkg::CmdWrite,  7'd0,   3'd5, 64'h8000_0000_8000_0001);
    send_item(bfp_pkg::CmdAppend, 7'd7,   3'd0, 64'h7F);
    send_item(CmdUnused,          7'd0,   3'd0, '0);
    send_item(bfp_pkg::CmdAppend, 7'd57,  3'd0, 64'h01FF_FFFF_FFFF_FFFF);

    for (int p = 0; p < 5; p++) begin
      src_idle_pct   = phase_src[p];
      sink_stall_pct = phase_sink[p];
      if (p == 4) long_hold_req = 1'b1;
      for (int i = 0; i < phase_items[p]; i++) send_random_item();
    end

    s_axis_tvalid  <= 1'b0;
    sink_stall_pct = 0;
    guard = 0;
    while (pending != 0 && guard < 5000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (20) @(negedge clk_i);

    $display("covered %0d append, %0d write, %0d align and %0d unused commands",
             cmd_seen[bfp_pkg::CmdAppend], cmd_seen[bfp_pkg::CmdWrite],
             cmd_seen[bfp_pkg::CmdAlign], cmd_seen[CmdUnused]);
    $display("compared %0d output bytes under idle, stall and long hold-off mixes", checked);
    if (pending != 0) $display("%0d expected bytes never arrived", pending);
    if (fail_cnt == 0 && pending == 0) begin
      $display("msb_first_bit_field_packer_unit test passed");
    end else begin
      $display("msb_first_bit_field_packer_unit test failed");
    end
    $finish;
  end

endmodule
